// ----- rtl/core/assert_macros.svh -----
// assertion macros shared by the charger rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked implication checked outside reset
`define BCSM_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// same check, also active while reset is held
`define BCSM_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- rtl/core/bcsm_pkg.sv -----
// types, codes and constants of the battery charger state machine
package bcsm_pkg;

  localparam int unsigned AdcW    = 12;
  localparam int unsigned CfgIdxW = 3;

  typedef logic [AdcW-1:0]        adc_t;
  typedef logic signed [AdcW-1:0] temp_t;

  // cell voltage plus this must not exceed charger voltage to reach handshake
  localparam logic [AdcW:0] HANDSHAKE_OFFSET = 13'd50;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_CURRENT_MAX   = 3'd0,
    CFG_VOLTAGE_MAX   = 3'd1,
    CFG_TEMP_MAX      = 3'd2,
    CFG_VOLTAGE_MIN   = 3'd3,
    CFG_VOLTAGE_BULK  = 3'd4,
    CFG_VOLTAGE_FULL  = 3'd5,
    CFG_CURRENT_TAPER = 3'd6,
    CFG_VOLTAGE_DEEP  = 3'd7
  } cfg_idx_t;

  localparam adc_t  RST_CURRENT_MAX   = 12'd3000;
  localparam adc_t  RST_VOLTAGE_MAX   = 12'd3900;
  localparam temp_t RST_TEMP_MAX      = 12'sd600;
  localparam adc_t  RST_VOLTAGE_MIN   = 12'd2000;
  localparam adc_t  RST_VOLTAGE_BULK  = 12'd3500;
  localparam adc_t  RST_VOLTAGE_FULL  = 12'd3700;
  localparam adc_t  RST_CURRENT_TAPER = 12'd400;
  localparam adc_t  RST_VOLTAGE_DEEP  = 12'd2500;

  typedef struct packed {
    adc_t  current_max;
    adc_t  voltage_max;
    temp_t temp_max;
    adc_t  voltage_min;
    adc_t  voltage_bulk;
    adc_t  voltage_full;
    adc_t  current_taper;
    adc_t  voltage_deep;
  } cfg_t;

  // charger state, one-hot
  typedef enum logic [6:0] {
    ST_CHECK     = 7'b0000001,
    ST_REQUEST   = 7'b0000010,
    ST_SOFT      = 7'b0000100,
    ST_HANDSHAKE = 7'b0001000,
    ST_CHARGING  = 7'b0010000,
    ST_FULL      = 7'b0100000,
    ST_PROTECT   = 7'b1000000
  } phase_t;

  // external state codes
  localparam logic [2:0] CODE_CHECK     = 3'd0;
  localparam logic [2:0] CODE_REQUEST   = 3'd1;
  localparam logic [2:0] CODE_SOFT      = 3'd2;
  localparam logic [2:0] CODE_HANDSHAKE = 3'd3;
  localparam logic [2:0] CODE_CHARGING  = 3'd4;
  localparam logic [2:0] CODE_FULL      = 3'd5;
  localparam logic [2:0] CODE_PROTECT   = 3'd6;
  localparam logic [2:0] CODE_UNUSED    = 3'd7;

  typedef enum logic [1:0] {
    PROT_NONE = 2'd0,
    PROT_OC   = 2'd1,
    PROT_OV   = 2'd2,
    PROT_OT   = 2'd3
  } prot_t;

  typedef enum logic [1:0] {
    MODE_NONE = 2'd0,
    MODE_CC   = 2'd1,
    MODE_CV   = 2'd2,
    MODE_FULL = 2'd3
  } mode_t;

  typedef struct packed {
    adc_t  out_voltage;
    adc_t  out_current;
    adc_t  cell_voltage;
    temp_t temperature;
    logic  relay_closed;
  } sample_t;

  typedef struct packed {
    phase_t phase;
    prot_t  prot;
    mode_t  mode;
  } eval_t;

  function automatic logic [2:0] encode_phase(phase_t ph);
    logic [2:0] code;
    unique case (ph)
      ST_CHECK:     code = CODE_CHECK;
      ST_REQUEST:   code = CODE_REQUEST;
      ST_SOFT:      code = CODE_SOFT;
      ST_HANDSHAKE: code = CODE_HANDSHAKE;
      ST_CHARGING:  code = CODE_CHARGING;
      ST_FULL:      code = CODE_FULL;
      ST_PROTECT:   code = CODE_PROTECT;
      default:      code = CODE_UNUSED;
    endcase
    return code;
  endfunction

endpackage

// ----- rtl/core/bcsm_in_if.sv -----
// sample channel: valid/ready handshake with one adc sample per transaction
interface bcsm_in_if import bcsm_pkg::*; ();
  logic  valid;
  logic  ready;
  adc_t  out_voltage;
  adc_t  out_current;
  adc_t  cell_voltage;
  temp_t temperature;
  logic  relay_closed;

  modport source (output valid, output out_voltage, output out_current,
                  output cell_voltage, output temperature, output relay_closed,
                  input ready);
  modport sink   (input valid, input out_voltage, input out_current,
                  input cell_voltage, input temperature, input relay_closed,
                  output ready);
endinterface

// ----- rtl/core/bcsm_out_if.sv -----
// result channel: valid/ready handshake with one charger status per transaction
interface bcsm_out_if ();
  logic       valid;
  logic       ready;
  logic [2:0] charger_state;
  logic [1:0] protection;
  logic [1:0] charge_mode;

  modport source (output valid, output charger_state, output protection,
                  output charge_mode, input ready);
  modport sink   (input valid, input charger_state, input protection,
                  input charge_mode, output ready);
endinterface

// ----- rtl/core/bcsm_cfg.sv -----
// threshold register file of the charger
module bcsm_cfg import bcsm_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [CfgIdxW-1:0] cfg_idx,
  input  logic [AdcW-1:0]    cfg_wdata,
  output cfg_t               cfg
);

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_idx))
        CFG_CURRENT_MAX:   cfg_nxt.current_max   = cfg_wdata;
        CFG_VOLTAGE_MAX:   cfg_nxt.voltage_max   = cfg_wdata;
        CFG_TEMP_MAX:      cfg_nxt.temp_max      = temp_t'(cfg_wdata);
        CFG_VOLTAGE_MIN:   cfg_nxt.voltage_min   = cfg_wdata;
        CFG_VOLTAGE_BULK:  cfg_nxt.voltage_bulk  = cfg_wdata;
        CFG_VOLTAGE_FULL:  cfg_nxt.voltage_full  = cfg_wdata;
        CFG_CURRENT_TAPER: cfg_nxt.current_taper = cfg_wdata;
        CFG_VOLTAGE_DEEP:  cfg_nxt.voltage_deep  = cfg_wdata;
        default:           cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.current_max   <= RST_CURRENT_MAX;
      cfg_r.voltage_max   <= RST_VOLTAGE_MAX;
      cfg_r.temp_max      <= RST_TEMP_MAX;
      cfg_r.voltage_min   <= RST_VOLTAGE_MIN;
      cfg_r.voltage_bulk  <= RST_VOLTAGE_BULK;
      cfg_r.voltage_full  <= RST_VOLTAGE_FULL;
      cfg_r.current_taper <= RST_CURRENT_TAPER;
      cfg_r.voltage_deep  <= RST_VOLTAGE_DEEP;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

// ----- rtl/core/bcsm_eval.sv -----
// protection, next charger state and charge mode for one sample
module bcsm_eval import bcsm_pkg::*; (
  input  sample_t smp,
  input  cfg_t    cfg,
  input  phase_t  phase,
  input  mode_t   mode_prev,
  output eval_t   res
);

  logic [AdcW:0] cell_plus_ofs;
  logic          low_cell;
  prot_t         prot;
  phase_t        phase_n;
  mode_t         mode_n;

  // no wrap: 13-bit sum
  assign cell_plus_ofs = {1'b0, smp.cell_voltage} + HANDSHAKE_OFFSET;
  assign low_cell      = smp.cell_voltage < cfg.voltage_min;

  always_comb begin
    priority if (smp.out_current > cfg.current_max) begin
      prot = PROT_OC;
    end else if (smp.out_voltage > cfg.voltage_max) begin
      prot = PROT_OV;
    end else if (smp.temperature > cfg.temp_max) begin
      prot = PROT_OT;
    end else begin
      prot = PROT_NONE;
    end
  end

  always_comb begin
    phase_n = phase;
    priority if (prot != PROT_NONE) begin
      phase_n = ST_PROTECT;
    end else if (low_cell && phase != ST_SOFT && phase != ST_HANDSHAKE &&
                 phase != ST_PROTECT) begin
      phase_n = ST_CHECK;
    end else if (phase == ST_CHECK && smp.cell_voltage < cfg.voltage_bulk && !low_cell) begin
      phase_n = ST_REQUEST;
    end else if (phase == ST_REQUEST) begin
      phase_n = ST_SOFT;
    end else if (phase == ST_SOFT && {1'b0, smp.out_voltage} >= cell_plus_ofs) begin
      phase_n = ST_HANDSHAKE;
    end else if (phase == ST_HANDSHAKE && smp.relay_closed) begin
      phase_n = ST_CHARGING;
    end else if (phase == ST_CHARGING && mode_prev == MODE_FULL) begin
      phase_n = ST_FULL;
    end else begin
      phase_n = phase;
    end
  end

  // current equal to taper falls through to the cc test
  always_comb begin
    priority if (smp.out_voltage >= cfg.voltage_full &&
                 smp.out_current < cfg.current_taper) begin
      mode_n = MODE_FULL;
    end else if (smp.out_voltage >= cfg.voltage_bulk &&
                 smp.out_current > cfg.current_taper) begin
      mode_n = MODE_CV;
    end else if (smp.out_voltage < cfg.voltage_bulk &&
                 smp.out_voltage > cfg.voltage_deep) begin
      mode_n = MODE_CC;
    end else begin
      mode_n = MODE_NONE;
    end
  end

  assign res = '{phase: phase_n, prot: prot, mode: mode_n};

endmodule

// ----- rtl/core/battery_charger_state_machine.sv -----
// top level of the cc/cv battery charger state machine
// One adc sample per transaction goes in, one status transaction comes out per sample:
// charger state, protection cause and charge mode. A sample is captured in an input
// register, evaluated by one level of comparators and a state update, and the status is
// held in an output register until it is taken. A new sample can be taken every cycle
// while results keep being taken; the rate is set by the single evaluation stage that
// also updates the state and mode registers.
// Over-current beats over-voltage beats over-temperature; any trip latches the protection
// state until reset. The user must write thresholds through the cfg port only while no
// sample is in flight; the block itself does not enforce this. Writes take effect at
// the next clock edge.
`include "assert_macros.svh"

module battery_charger_state_machine import bcsm_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [CfgIdxW-1:0] cfg_idx,
  input  logic [AdcW-1:0]    cfg_wdata,
  bcsm_in_if.sink            in_if,
  bcsm_out_if.source         out_if
);

  cfg_t cfg;

  // input register stage
  logic    s1_valid_r, s1_valid_nxt;
  sample_t s1_smp_r;
  logic    s1_adv;

  // architectural state: charger phase and mode of the previous sample
  phase_t  phase_r, phase_nxt;
  mode_t   mode_r, mode_nxt;

  // result register
  logic    out_valid_r, out_valid_nxt;
  eval_t   out_res_r;

  eval_t   eval_res;
  logic    in_take;

  sample_t in_smp;

  bcsm_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  // stage 1 moves on when the result register is free or being drained
  assign s1_adv   = s1_valid_r && (!out_valid_r || out_if.ready);
  assign in_if.ready = !s1_valid_r || s1_adv;
  assign in_take  = in_if.valid && in_if.ready;

  assign in_smp.out_voltage  = in_if.out_voltage;
  assign in_smp.out_current  = in_if.out_current;
  assign in_smp.cell_voltage = in_if.cell_voltage;
  assign in_smp.temperature  = in_if.temperature;
  assign in_smp.relay_closed = in_if.relay_closed;

  bcsm_eval u_eval (
    .smp       (s1_smp_r),
    .cfg       (cfg),
    .phase     (phase_r),
    .mode_prev (mode_r),
    .res       (eval_res)
  );

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_take) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_adv) begin
      s1_valid_nxt = 1'b0;
    end
  end

  // state commits only when the evaluated sample lands in the result register
  assign phase_nxt = s1_adv ? eval_res.phase : phase_r;
  assign mode_nxt  = s1_adv ? eval_res.mode  : mode_r;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (s1_adv) begin
      out_valid_nxt = 1'b1;
    end else if (out_if.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      phase_r     <= ST_CHECK;
      mode_r      <= MODE_NONE;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      phase_r     <= phase_nxt;
      mode_r      <= mode_nxt;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_smp_r <= in_smp;
    end
    if (s1_adv) begin
      out_res_r <= eval_res;
    end
  end

  assign out_if.valid         = out_valid_r;
  assign out_if.charger_state = encode_phase(out_res_r.phase);
  assign out_if.protection    = out_res_r.prot;
  assign out_if.charge_mode   = out_res_r.mode;

  // protection latches until reset
  `BCSM_ASSERT(a_prot_latch, phase_r == ST_PROTECT |=> phase_r == ST_PROTECT, "protection state left")
  // a reported trip always comes with the protection state
  `BCSM_ASSERT(a_trip_state, out_valid_r && out_res_r.prot != PROT_NONE |-> out_res_r.phase == ST_PROTECT, "trip without protection state")
  // state and mode change only when a sample is evaluated
  `BCSM_ASSERT(a_state_hold, !s1_adv |=> $stable(phase_r) && $stable(mode_r), "state moved without a sample")
  // state stays one-hot, checked whenever $past(rst_n) is high
  `BCSM_ASSERT_ALWAYS(a_phase_onehot, $past(rst_n) |-> $onehot(phase_r), "phase not one-hot")

endmodule

// ----- bench/battery_charger_state_machine_checker.sv -----
// status predictor and scoreboard for the battery charger state machine
`timescale 1ns / 100ps

module battery_charger_state_machine_checker import bcsm_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [CfgIdxW-1:0] cfg_idx,
  input  logic [AdcW-1:0]    cfg_wdata,
  bcsm_in_if                 in_mon,
  bcsm_out_if                out_mon,
  output int                 mismatches,
  output int                 outstanding,
  output int                 checked,
  output logic [7:0]         states_seen
);

  localparam logic [AdcW:0] HS_MARGIN    = 13'd50;
  localparam int            REPORT_LIMIT = 10;

  typedef struct packed {
    logic [2:0] state;
    prot_t      prot;
    mode_t      mode;
  } status_t;

  cfg_t       thr;
  logic [2:0] state_code;
  mode_t      last_mode;
  status_t    status_q[$];
  int         n_bad   = 0;
  int         n_done  = 0;
  logic [7:0] reached = '0;

  // new charger status for one sample; advances the state and mode copies
  function automatic status_t charger_status(input sample_t s);
    status_t r;
    prot_t   cause;
    mode_t   mode;
    logic    low_cell;
    if (s.out_current > thr.current_max) begin
      cause = PROT_OC;
    end else if (s.out_voltage > thr.voltage_max) begin
      cause = PROT_OV;
    end else if ($signed(s.temperature) > $signed(thr.temp_max)) begin
      cause = PROT_OT;
    end else begin
      cause = PROT_NONE;
    end
    low_cell = s.cell_voltage < thr.voltage_min;

    if (cause != PROT_NONE) begin
      state_code = CODE_PROTECT;
    end else if (low_cell &&
                 !(state_code inside {CODE_SOFT, CODE_HANDSHAKE, CODE_PROTECT})) begin
      state_code = CODE_CHECK;
    end else begin
      case (state_code)
        // cell is at or above minimum here, otherwise the drop above was taken
        CODE_CHECK: begin
          if (s.cell_voltage < thr.voltage_bulk) state_code = CODE_REQUEST;
        end
        CODE_REQUEST: begin
          state_code = CODE_SOFT;
        end
        CODE_SOFT: begin
          if ({1'b0, s.out_voltage} >= {1'b0, s.cell_voltage} + HS_MARGIN)
            state_code = CODE_HANDSHAKE;
        end
        CODE_HANDSHAKE: begin
          if (s.relay_closed) state_code = CODE_CHARGING;
        end
        CODE_CHARGING: begin
          if (last_mode == MODE_FULL) state_code = CODE_FULL;
        end
        default: ;
      endcase
    end

    if (s.out_voltage >= thr.voltage_full && s.out_current < thr.current_taper) begin
      mode = MODE_FULL;
    end else if (s.out_voltage >= thr.voltage_bulk && s.out_current > thr.current_taper) begin
      mode = MODE_CV;
    end else if (s.out_voltage < thr.voltage_bulk && s.out_voltage > thr.voltage_deep) begin
      mode = MODE_CC;
    end else begin
      mode = MODE_NONE;
    end
    last_mode = mode;

    r.state = state_code;
    r.prot  = cause;
    r.mode  = mode;
    return r;
  endfunction

  task automatic flag(input string msg);
    n_bad++;
    if (n_bad <= REPORT_LIMIT) $display("%s", msg);
  endtask

  always @(posedge clk) begin
    sample_t s;
    status_t want;
    if (!rst_n) begin
      thr.current_max   = RST_CURRENT_MAX;
      thr.voltage_max   = RST_VOLTAGE_MAX;
      thr.temp_max      = RST_TEMP_MAX;
      thr.voltage_min   = RST_VOLTAGE_MIN;
      thr.voltage_bulk  = RST_VOLTAGE_BULK;
      thr.voltage_full  = RST_VOLTAGE_FULL;
      thr.current_taper = RST_CURRENT_TAPER;
      thr.voltage_deep  = RST_VOLTAGE_DEEP;
      state_code = CODE_CHECK;
      last_mode  = MODE_NONE;
      status_q.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_idx)
          CFG_CURRENT_MAX:   thr.current_max   = cfg_wdata;
          CFG_VOLTAGE_MAX:   thr.voltage_max   = cfg_wdata;
          CFG_TEMP_MAX:      thr.temp_max      = cfg_wdata;
          CFG_VOLTAGE_MIN:   thr.voltage_min   = cfg_wdata;
          CFG_VOLTAGE_BULK:  thr.voltage_bulk  = cfg_wdata;
          CFG_VOLTAGE_FULL:  thr.voltage_full  = cfg_wdata;
          CFG_CURRENT_TAPER: thr.current_taper = cfg_wdata;
          CFG_VOLTAGE_DEEP:  thr.voltage_deep  = cfg_wdata;
          default: ;
        endcase
      end

      if (in_mon.valid && in_mon.ready) begin
        s.out_voltage  = in_mon.out_voltage;
        s.out_current  = in_mon.out_current;
        s.cell_voltage = in_mon.cell_voltage;
        s.temperature  = in_mon.temperature;
        s.relay_closed = in_mon.relay_closed;
        status_q.push_back(charger_status(s));
        reached[state_code] = 1'b1;
      end

      if (out_mon.valid && out_mon.ready) begin
        if (status_q.size() == 0) begin
          flag($sformatf("unexpected status at %0t: state %0d prot %0d mode %0d",
                         $time, out_mon.charger_state, out_mon.protection,
                         out_mon.charge_mode));
        end else begin
          want = status_q.pop_front();
          n_done++;
          if (out_mon.charger_state !== want.state ||
              out_mon.protection !== want.prot ||
              out_mon.charge_mode !== want.mode) begin
            flag($sformatf({"status mismatch at %0t: expected state %0d prot %0d mode %0d,",
                            " got state %0d prot %0d mode %0d"},
                           $time, want.state, want.prot, want.mode,
                           out_mon.charger_state, out_mon.protection,
                           out_mon.charge_mode));
          end
        end
      end
    end
    mismatches  <= n_bad;
    outstanding <= status_q.size();
    checked     <= n_done;
    states_seen <= reached;
  end

endmodule

// ----- bench/battery_charger_state_machine_tb.sv -----
// top of the battery charger state machine testbench: clock, reset, stimulus and verdict
`timescale 1ns / 100ps

module battery_charger_state_machine_tb;
  import bcsm_pkg::*;

  localparam int LONG_STALL  = 300;   // receiver hold-off, long enough to back up the input
  localparam int DRAIN_LIMIT = 5000;  // cycles allowed for outstanding statuses to arrive
  localparam int SETTLE      = 4;     // pipeline plus margin

  // what a generated sample aims at in the charge sequence
  typedef enum int {
    SMP_NOISE,      // anything at all
    SMP_REQUEST,    // cell inside the request window
    SMP_HOLD,       // cell at or above minimum, so no low-cell drop
    SMP_SOFT_WAIT,  // charger voltage short of the handshake margin
    SMP_SOFT_GO,    // charger voltage clears the handshake margin
    SMP_HS_WAIT,    // relay still open
    SMP_HS_GO,      // relay closed
    SMP_CHARGE,     // cell held up, charger side steered toward a mode
    SMP_DROP        // cell under minimum
  } sample_aim_t;

  logic               clk = 1'b0;
  logic               rst_n;
  logic               cfg_we;
  logic [CfgIdxW-1:0] cfg_idx;
  logic [AdcW-1:0]    cfg_wdata;

  bcsm_in_if  in_ch();
  bcsm_out_if out_ch();

  // handshake pacing, written only by the main sequence
  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  // long receiver hold-off: main bumps the request, the receiver acknowledges
  int stall_req = 0;
  int stall_ack = 0;

  int   items_sent    = 0;
  int   settings_used = 1;
  cfg_t cur;  // thresholds currently in the block, used only to shape samples

  int         mismatches;
  int         outstanding;
  int         checked;
  logic [7:0] states_seen;

  battery_charger_state_machine DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .in_if     (in_ch),
    .out_if    (out_ch)
  );

  battery_charger_state_machine_checker status_check (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_we      (cfg_we),
    .cfg_idx     (cfg_idx),
    .cfg_wdata   (cfg_wdata),
    .in_mon      (in_ch),
    .out_mon     (out_ch),
    .mismatches  (mismatches),
    .outstanding (outstanding),
    .checked     (checked),
    .states_seen (states_seen)
  );

  // 20 ns clock
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // run limit, far beyond the slowest legal run
  initial begin
    #5_000_000;
    $display("timeout with %0d status transactions still outstanding", outstanding);
    $display("battery_charger_state_machine_tb: errors");
    $finish;
  end

  // status receiver: random back-pressure, plus the long hold-off on request
  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (stall_req != stall_ack) begin
        out_ch.ready <= 1'b0;
        repeat (LONG_STALL - 1) @(posedge clk);
        stall_ack++;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  // random value in [lo, hi], clipped to the adc range
  function automatic int pick(input int lo, input int hi);
    if (lo < 0) lo = 0;
    if (lo > 4095) lo = 4095;
    if (hi > 4095) hi = 4095;
    if (hi < lo) hi = lo;
    return int'($urandom_range(hi, lo));
  endfunction

  // bias toward the ends of the adc range
  function automatic int corner_or_any();
    case ($urandom_range(7))
      0:       return 0;
      1:       return 4095;
      default: return int'($urandom_range(4095));
    endcase
  endfunction

  function automatic sample_t make_sample(input sample_aim_t aim);
    sample_t s;
    int      vc;
    int      t;
    t = int'($urandom_range(1900)) - 400;
    s.out_voltage  = adc_t'($urandom_range(4095));
    s.out_current  = adc_t'($urandom_range(4095));
    s.cell_voltage = adc_t'($urandom_range(4095));
    s.temperature  = temp_t'(t);
    s.relay_closed = 1'($urandom_range(1));
    case (aim)
      SMP_NOISE: begin
        s.out_voltage  = adc_t'(corner_or_any());
        s.out_current  = adc_t'(corner_or_any());
        s.cell_voltage = adc_t'(corner_or_any());
        if ($urandom_range(7) == 0) s.temperature = temp_t'(-400);
        else if ($urandom_range(7) == 0) s.temperature = temp_t'(1500);
      end
      SMP_REQUEST: begin
        s.cell_voltage = adc_t'(pick(int'(cur.voltage_min), int'(cur.voltage_bulk) - 1));
      end
      SMP_HOLD: begin
        s.cell_voltage = adc_t'(pick(int'(cur.voltage_min), 4095));
      end
      SMP_SOFT_WAIT: begin
        vc = pick(0, 4095);
        s.cell_voltage = adc_t'(vc);
        s.out_voltage  = adc_t'(pick(0, vc + 49));
      end
      SMP_SOFT_GO: begin
        vc = pick(0, 4045);
        s.cell_voltage = adc_t'(vc);
        s.out_voltage  = adc_t'(pick(vc + 50, 4095));
      end
      SMP_HS_WAIT: s.relay_closed = 1'b0;
      SMP_HS_GO:   s.relay_closed = 1'b1;
      SMP_CHARGE: begin
        s.cell_voltage = adc_t'(pick(int'(cur.voltage_min), 4095));
        case ($urandom_range(3))
          0: begin  // toward full
            s.out_voltage = adc_t'(pick(int'(cur.voltage_full), 4095));
            s.out_current = adc_t'(pick(0, int'(cur.current_taper) - 1));
          end
          1: begin  // toward constant voltage
            s.out_voltage = adc_t'(pick(int'(cur.voltage_bulk), 4095));
            s.out_current = adc_t'(pick(int'(cur.current_taper) + 1, 4095));
          end
          2: begin  // toward constant current
            s.out_voltage = adc_t'(pick(int'(cur.voltage_deep) + 1,
                                        int'(cur.voltage_bulk) - 1));
          end
          default: ;
        endcase
      end
      SMP_DROP: begin
        s.cell_voltage = adc_t'(pick(0, int'(cur.voltage_min) - 1));
      end
      default: ;
    endcase
    return s;
  endfunction

  // offer one sample, with random sender gaps first; returns at the accepting edge
  task automatic send_sample(input sample_t s);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.out_voltage  <= s.out_voltage;
    in_ch.out_current  <= s.out_current;
    in_ch.cell_voltage <= s.cell_voltage;
    in_ch.temperature  <= s.temperature;
    in_ch.relay_closed <= s.relay_closed;
    do @(posedge clk); while (!in_ch.ready);
    items_sent++;
  endtask

  task automatic send_fields(input int vout, input int iout, input int vcell,
                             input int temp, input logic relay);
    sample_t s;
    s.out_voltage  = adc_t'(vout);
    s.out_current  = adc_t'(iout);
    s.cell_voltage = adc_t'(vcell);
    s.temperature  = temp_t'(temp);
    s.relay_closed = relay;
    send_sample(s);
  endtask

  // wait for every status to come back, then let the pipeline settle
  task automatic drain();
    int n;
    n = 0;
    do begin
      @(posedge clk);
      n++;
    end while (outstanding != 0 && n < DRAIN_LIMIT);
    repeat (SETTLE) @(posedge clk);
  endtask

  function automatic logic [AdcW-1:0] reg_value(input cfg_t c, input cfg_idx_t idx);
    case (idx)
      CFG_CURRENT_MAX:   return c.current_max;
      CFG_VOLTAGE_MAX:   return c.voltage_max;
      CFG_TEMP_MAX:      return c.temp_max;
      CFG_VOLTAGE_MIN:   return c.voltage_min;
      CFG_VOLTAGE_BULK:  return c.voltage_bulk;
      CFG_VOLTAGE_FULL:  return c.voltage_full;
      CFG_CURRENT_TAPER: return c.current_taper;
      default:           return c.voltage_deep;
    endcase
  endfunction

  // write all eight thresholds, one per cycle; block must be idle
  task automatic apply_settings(input cfg_t c);
    cfg_idx_t idx;
    cur = c;
    settings_used++;
    idx = CFG_CURRENT_MAX;
    do begin
      cfg_we    <= 1'b1;
      cfg_idx   <= idx;
      cfg_wdata <= reg_value(c, idx);
      @(posedge clk);
      idx = idx.next();
    end while (idx != CFG_CURRENT_MAX);
    cfg_we <= 1'b0;
  endtask

  // one charge cycle from battery check to full and back, sometimes cut short
  task automatic charge_cycle();
    send_sample(make_sample(SMP_REQUEST));
    if ($urandom_range(9) == 0) begin
      // aborted right after the request
      send_sample(make_sample(SMP_DROP));
      return;
    end
    send_sample(make_sample(SMP_HOLD));
    repeat ($urandom_range(3)) send_sample(make_sample(SMP_SOFT_WAIT));
    send_sample(make_sample(SMP_SOFT_GO));
    repeat ($urandom_range(2)) send_sample(make_sample(SMP_HS_WAIT));
    send_sample(make_sample(SMP_HS_GO));
    repeat ($urandom_range(8, 1)) send_sample(make_sample(SMP_CHARGE));
    send_sample(make_sample(SMP_DROP));
  endtask

  // mostly full charge cycles, some bursts of noise; ends with valid low
  task automatic charge_traffic(input int count);
    int start;
    start = items_sent;
    while (items_sent - start < count) begin
      if ($urandom_range(99) < 15) begin
        repeat ($urandom_range(4, 1)) send_sample(make_sample(SMP_NOISE));
        send_sample(make_sample(SMP_DROP));
      end else begin
        charge_cycle();
      end
    end
    in_ch.valid <= 1'b0;
  endtask

  function automatic cfg_t make_cfg(input int i_max, input int v_max, input int t_max,
                                    input int v_min, input int v_bulk, input int v_full,
                                    input int i_taper, input int v_deep);
    cfg_t c;
    c.current_max   = adc_t'(i_max);
    c.voltage_max   = adc_t'(v_max);
    c.temp_max      = temp_t'(t_max);
    c.voltage_min   = adc_t'(v_min);
    c.voltage_bulk  = adc_t'(v_bulk);
    c.voltage_full  = adc_t'(v_full);
    c.current_taper = adc_t'(i_taper);
    c.voltage_deep  = adc_t'(v_deep);
    return c;
  endfunction

  initial begin
    // every block input at a known value from time zero
    rst_n              <= 1'b0;
    cfg_we             <= 1'b0;
    cfg_idx            <= CFG_CURRENT_MAX;
    cfg_wdata          <= '0;
    in_ch.valid        <= 1'b0;
    in_ch.out_voltage  <= '0;
    in_ch.out_current  <= '0;
    in_ch.cell_voltage <= '0;
    in_ch.temperature  <= '0;
    in_ch.relay_closed <= 1'b0;
    cur = make_cfg(int'(RST_CURRENT_MAX), int'(RST_VOLTAGE_MAX), int'(RST_TEMP_MAX),
                   int'(RST_VOLTAGE_MIN), int'(RST_VOLTAGE_BULK), int'(RST_VOLTAGE_FULL),
                   int'(RST_CURRENT_TAPER), int'(RST_VOLTAGE_DEEP));

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // sender gaps light, receiver heavy
    tx_idle_pct = 17;
    rx_idle_pct = 69;

    // directed walk at reset thresholds, staying clear of every trip level
    send_fields(0,    0,    1999, -400, 1'b0);  // low cell in check
    send_fields(3499, 3000, 3500, 600,  1'b0);  // cell at bulk: no request; trips at their limits
    send_fields(3700, 400,  2000, 0,    1'b1);  // request; current equal to taper
    send_fields(3000, 400,  1999, 0,    1'b0);  // low cell drops request back to check
    send_fields(2500, 0,    3499, 0,    1'b0);  // request again, voltage equal to deep level
    send_fields(3900, 100,  3000, 0,    1'b0);  // soft start, full-looking mode
    send_fields(1049, 0,    1000, 0,    1'b1);  // soft start ignores low cell, one short of margin
    send_fields(3900, 0,    4060, 0,    1'b0);  // margin sum past 12 bits must not wrap
    send_fields(1050, 0,    1000, 0,    1'b0);  // exactly at margin: handshake
    send_fields(0,    0,    0,    0,    1'b0);  // handshake ignores low cell, relay open
    send_fields(3800, 100,  3000, 0,    1'b1);  // relay closed: charging, mode full
    send_fields(3600, 3000, 2500, 0,    1'b0);  // previous mode full: full charged
    send_fields(3700, 0,    2000, 600,  1'b0);  // full holds
    send_fields(0,    0,    1999, 0,    1'b0);  // low cell from full
    send_fields(3000, 1000, 2500, 0,    1'b0);  // request
    send_fields(2000, 0,    2500, 0,    1'b0);  // soft start
    send_fields(2600, 0,    2550, 0,    1'b0);  // handshake on exact margin
    send_fields(3000, 1000, 2500, 0,    1'b1);  // charging in constant current
    send_fields(3900, 0,    3000, 0,    1'b0);  // previous mode cc: stays charging
    send_fields(3000, 1000, 3000, -1,   1'b1);  // previous mode full: full charged
    send_fields(0,    3000, 0,    -400, 1'b0);  // back to check
    in_ch.valid <= 1'b0;
    drain();

    // trips out of reach so every input bit can toggle without latching protection
    apply_settings(make_cfg(4095, 4095, 1500, 2000, 3500, 3700, 400, 2500));
    charge_traffic(500);
    drain();

    // sender gaps heavy, receiver light; low-end thresholds
    tx_idle_pct = 69;
    rx_idle_pct = 17;
    apply_settings(make_cfg(4095, 4095, 1500, 1, 4095, 4095, 0, 0));
    charge_traffic(250);
    drain();  // sender pauses until every status is back
    charge_traffic(250);
    drain();

    // no idling either side; narrow request window and high-end mode levels
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    apply_settings(make_cfg(4095, 4095, 1500, 2500, 2600, 0, 4095, 4095));
    charge_traffic(200);
    // long receiver hold-off while samples keep coming: the block must stall its input
    stall_req++;
    charge_traffic(250);
    drain();

    // protection last, since only reset would clear the latch
    apply_settings(make_cfg(2000, 3000, 0, 0, 4095, 4095, 0, 0));
    send_fields(3001, 2001, 2500, 1, 1'b0);  // all three causes: over-current wins
    send_fields(3001, 2000, 2500, 1, 1'b0);  // over-voltage beats over-temperature
    send_fields(3000, 0,    2500, 1, 1'b0);  // over-temperature alone
    send_fields(3000, 2000, 0,    0, 1'b1);  // cause gone, state stays latched
    in_ch.valid <= 1'b0;
    drain();
    charge_traffic(150);
    drain();

    // trip levels at their floor: nearly every sample trips
    apply_settings(make_cfg(0, 0, -400, 4095, 0, 2048, 2048, 1000));
    charge_traffic(150);
    drain();

    $display("run covered %0d samples under %0d threshold settings, %0d statuses checked",
             items_sent, settings_used, checked);
    $display("charger state codes reached (bit per code): %b", states_seen);
    if (outstanding != 0)
      $display("%0d status transactions never arrived", outstanding);
    if (mismatches == 0 && outstanding == 0) begin
      $display("battery_charger_state_machine_tb: clean");
    end else begin
      $display("battery_charger_state_machine_tb: errors");
    end
    $finish;
  end

endmodule
